// ===== hdl/psb_pkg.sv =====
// Package for the prime sieve bitmap: shared constants, mode codes,
// sequencer states, the structs passed between the row unit and the sequencer and the response struct.
// Depends on nothing.
package psb_pkg;

    localparam int MODE_W  = 2;
    localparam int VAL_W   = 10;
    localparam int LIMIT_W = 20;

    // The bitmap is held as rows of sixteen flags.
    localparam int ROW_W = 16;
    localparam int BIT_W = 4;

    // Divisor and divisor square widths: m*m <= limit keeps m below 2**(LIMIT_W/2).
    localparam int M_W   = LIMIT_W / 2 + 1;
    localparam int SQ_W  = LIMIT_W + 1;
    localparam int M_MAX = 1 << (M_W - 1);

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIEVE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef logic [VAL_W-1:0] t_val;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FIRST,
        ST_SCAN,
        ST_SV_RD,
        ST_SV_WR,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        ROP_SCAN,
        ROP_SET,
        ROP_CLR
    } t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic [BIT_W-1:0] bit_idx;
    } t_row_ctl;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic             bit_val;
        logic             hit;
        logic [BIT_W-1:0] idx;
    } t_row_res;

    typedef struct packed {
        logic member;
        logic found;
        t_val next_member;
    } t_rsp;

endpackage

// ===== hdl/psb_in_if.sv =====
// Request channel of the prime sieve bitmap: valid, ready and one request beat.
// Depends on psb_pkg.
interface psb_in_if;
    logic                        valid;
    logic                        ready;
    logic [psb_pkg::MODE_W-1:0]  mode;
    logic [psb_pkg::VAL_W-1:0]   value;
    logic [psb_pkg::LIMIT_W-1:0] limit;

    modport source (output valid, output mode, output value, output limit, input ready);
    modport sink   (input valid, input mode, input value, input limit, output ready);
endinterface

// ===== hdl/psb_out_if.sv =====
// Response channel of the prime sieve bitmap: valid, ready and one response beat.
// Depends on psb_pkg.
interface psb_out_if;
    logic                      valid;
    logic                      ready;
    logic                      member;
    logic                      found;
    logic [psb_pkg::VAL_W-1:0] next_member;

    modport source (output valid, output member, output found, output next_member,
                    input ready);
    modport sink   (input valid, input member, input found, input next_member,
                    output ready);
endinterface

// ===== hdl/prime_sieve_bitmap_top.sv =====
// Top level of the prime sieve bitmap: sequencer, bitmap RAM and shared row unit.
// Depends on psb_pkg, psb_in_if, psb_out_if, psb_ram and psb_row_unit.
//
//   Channel  Dir  Beat contents                 Handshake
//   i_req    in   mode, value, limit            valid/ready
//   o_rsp    out  member, found, next_member    valid/ready
//
// An insert or query reads the row of its value, then one further bitmap row of
// sixteen values at a time to find the next member; the single RAM read port sets this.
// A sieve run reads, then writes back, the row of each multiple struck.
// After reset a clearing pass writes ceil(MAX_VALUE/16) rows, one per cycle, before
// the first request beat is taken. One request is worked on at a time; a finished
// response waits in the output register while the next request is taken.
module prime_sieve_bitmap_top #(
    parameter int MAX_VALUE = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    psb_in_if.sink    i_req,
    psb_out_if.source o_rsp
);
    localparam int ROWS = (MAX_VALUE + psb_pkg::ROW_W - 1) / psb_pkg::ROW_W;
    localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int XW   = $clog2(MAX_VALUE + 2 * psb_pkg::M_MAX + 1);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    psb_pkg::t_state            r_state, n_state;
    logic [AW-1:0]              r_row, n_row;
    logic [psb_pkg::MODE_W-1:0] r_mode, n_mode;
    psb_pkg::t_val              r_value, n_value;
    logic [psb_pkg::LIMIT_W-1:0] r_lim, n_lim;
    logic [psb_pkg::M_W-1:0]    r_m, n_m;
    logic [psb_pkg::SQ_W-1:0]   r_sq, n_sq;
    logic [XW-1:0]              r_x, n_x;
    psb_pkg::t_rsp              r_pend, n_pend;
    psb_pkg::t_rsp              r_out, n_out;
    logic                       r_out_valid, n_out_valid;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [psb_pkg::ROW_W-1:0]  ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [psb_pkg::ROW_W-1:0]  ram_rdata;
    psb_pkg::t_row_ctl          row_ctl;
    psb_pkg::t_row_res          row_res;

    logic                       in_accept;
    logic [AW-1:0]              x_row;
    logic [XW-1:0]              nx;
    logic [psb_pkg::M_W-1:0]    m_nxt;
    logic [psb_pkg::SQ_W-1:0]   sq_nxt;

    psb_ram #(
        .WIDTH (psb_pkg::ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    psb_row_unit u_row_unit (
        .i_row (ram_rdata),
        .i_ctl (row_ctl),
        .o_res (row_res)
    );

    assign i_req.ready       = (r_state == psb_pkg::ST_IDLE);
    assign in_accept         = i_req.valid && i_req.ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.member      = r_out.member;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.next_member = r_out.next_member;

    assign x_row  = AW'(r_x >> psb_pkg::BIT_W);
    assign nx     = (r_x == '0) ? XW'({r_m, 1'b0}) : r_x + XW'(r_m);
    assign m_nxt  = r_m + psb_pkg::M_W'(1);
    assign sq_nxt = r_sq + psb_pkg::SQ_W'({r_m, 1'b0}) + psb_pkg::SQ_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psb_pkg::ST_CLEAR;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_out_valid <= n_out_valid;
        end
        r_mode  <= n_mode;
        r_value <= n_value;
        r_lim   <= n_lim;
        r_m     <= n_m;
        r_sq    <= n_sq;
        r_x     <= n_x;
        r_pend  <= n_pend;
        r_out   <= n_out;
    end

    always_comb begin
        n_state         = r_state;
        n_row           = r_row;
        n_mode          = r_mode;
        n_value         = r_value;
        n_lim           = r_lim;
        n_m             = r_m;
        n_sq            = r_sq;
        n_x             = r_x;
        n_pend          = r_pend;
        n_out           = r_out;
        n_out_valid     = r_out_valid && !o_rsp.ready;
        ram_we          = 1'b0;
        ram_waddr       = r_row;
        ram_wdata       = row_res.row;
        ram_raddr       = r_row;
        row_ctl.op      = psb_pkg::ROP_SCAN;
        row_ctl.bit_idx = '0;

        case (r_state)
            psb_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (r_row == LAST_ROW) begin
                    n_row   = '0;
                    n_state = psb_pkg::ST_IDLE;
                end else begin
                    n_row = r_row + AW'(1);
                end
            end
            psb_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_mode  = i_req.mode;
                    n_value = i_req.value;
                    n_lim   = i_req.limit;
                    n_pend  = '0;
                    n_state = psb_pkg::ST_DONE;
                    if (i_req.mode inside {psb_pkg::MODE_INSERT, psb_pkg::MODE_QUERY}) begin
                        if (32'(i_req.value) < MAX_VALUE) begin
                            n_row     = AW'(i_req.value >> psb_pkg::BIT_W);
                            ram_raddr = AW'(i_req.value >> psb_pkg::BIT_W);
                            n_state   = psb_pkg::ST_FIRST;
                        end
                    end else if (i_req.mode == psb_pkg::MODE_SIEVE) begin
                        if (i_req.limit >= psb_pkg::LIMIT_W'(4)) begin
                            n_m     = psb_pkg::M_W'(2);
                            n_sq    = psb_pkg::SQ_W'(4);
                            n_x     = '0;
                            n_state = psb_pkg::ST_SV_RD;
                        end
                    end
                end
            end
            psb_pkg::ST_FIRST, psb_pkg::ST_SCAN: begin
                if (r_state == psb_pkg::ST_FIRST) begin
                    row_ctl.bit_idx = r_value[psb_pkg::BIT_W-1:0];
                    n_pend.member   = row_res.bit_val;
                    if (r_mode == psb_pkg::MODE_INSERT) begin
                        row_ctl.op = psb_pkg::ROP_SET;
                        ram_we     = 1'b1;
                    end
                end
                if (row_res.hit) begin
                    n_pend.found       = 1'b1;
                    n_pend.next_member = psb_pkg::t_val'({r_row, row_res.idx});
                    n_state            = psb_pkg::ST_DONE;
                end else if (r_row == LAST_ROW) begin
                    n_state = psb_pkg::ST_DONE;
                end else begin
                    n_row     = r_row + AW'(1);
                    ram_raddr = r_row + AW'(1);
                    n_state   = psb_pkg::ST_SCAN;
                end
            end
            psb_pkg::ST_SV_RD: begin
                ram_raddr = x_row;
                n_state   = psb_pkg::ST_SV_WR;
            end
            psb_pkg::ST_SV_WR: begin
                row_ctl.op      = psb_pkg::ROP_CLR;
                row_ctl.bit_idx = r_x[psb_pkg::BIT_W-1:0];
                ram_we          = 1'b1;
                ram_waddr       = x_row;
                if (32'(nx) < MAX_VALUE) begin
                    n_x     = nx;
                    n_state = psb_pkg::ST_SV_RD;
                end else if ((sq_nxt <= psb_pkg::SQ_W'(r_lim))
                             && (32'({m_nxt, 1'b0}) < MAX_VALUE)) begin
                    n_m     = m_nxt;
                    n_sq    = sq_nxt;
                    n_x     = XW'({m_nxt, 1'b0});
                    n_state = psb_pkg::ST_SV_RD;
                end else begin
                    n_state = psb_pkg::ST_DONE;
                end
            end
            psb_pkg::ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_pend;
                    n_out_valid = 1'b1;
                    n_state     = psb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = psb_pkg::ST_IDLE;
            end
        endcase
    end

    a_no_beat_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psb_pkg::ST_CLEAR) |-> !i_req.ready)
        else $error("Request beat offered while the bitmap is being cleared.");

    a_insert_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psb_pkg::ST_FIRST && r_mode == psb_pkg::MODE_INSERT)
        |-> (ram_we && row_res.bit_val && row_res.hit))
        else $error("Insert did not write back a row with the flag set.");

    a_sieve_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psb_pkg::ST_SV_WR) |-> (32'(r_x) < MAX_VALUE))
        else $error("Sieve strike beyond the bitmap.");

    a_sieve_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psb_pkg::ST_SV_RD)
        |-> (r_sq == psb_pkg::SQ_W'(r_m) * psb_pkg::SQ_W'(r_m))
            && (r_sq <= psb_pkg::SQ_W'(r_lim)))
        else $error("Sieve divisor square out of step with the divisor or the limit.");

    a_sieve_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psb_pkg::ST_DONE && r_mode == psb_pkg::MODE_SIEVE) |-> (r_pend == '0))
        else $error("Sieve response carries a non-zero field.");
endmodule

// ===== hdl/psb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module psb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/psb_row_unit.sv =====
// Shared row unit: sets, clears or passes one flag of a bitmap row and finds the
// lowest set flag at or above the selected position. Depends on psb_pkg.
module psb_row_unit (
    input  logic [psb_pkg::ROW_W-1:0] i_row,
    input  psb_pkg::t_row_ctl         i_ctl,
    output psb_pkg::t_row_res         o_res
);
    logic [psb_pkg::ROW_W-1:0] onehot;
    logic [psb_pkg::ROW_W-1:0] row;
    logic [psb_pkg::ROW_W-1:0] hits;
    logic [psb_pkg::BIT_W-1:0] idx;

    always_comb begin
        onehot = psb_pkg::ROW_W'(1) << i_ctl.bit_idx;
        case (i_ctl.op)
            psb_pkg::ROP_SET: row = i_row | onehot;
            psb_pkg::ROP_CLR: row = i_row & ~onehot;
            default:          row = i_row;
        endcase
        hits = row & ({psb_pkg::ROW_W{1'b1}} << i_ctl.bit_idx);
        idx  = '0;
        for (int k = psb_pkg::ROW_W - 1; k >= 0; k--) begin
            if (hits[k]) begin
                idx = psb_pkg::BIT_W'(k);
            end
        end
        o_res.row     = row;
        o_res.bit_val = row[i_ctl.bit_idx];
        o_res.hit     = |hits;
        o_res.idx     = idx;
    end
endmodule
